FILE: rtl/core/tzbo_pkg.sv
// Shared types and constants for the zone band occupancy block.
`default_nettype none
package tzbo_pkg;

   localparam int BAND_COUNT  = 6;
   localparam int ZONE_COUNT  = 64;
   localparam int MASK_BITS   = 6;
   localparam int COUNT_W     = 7;
   localparam int QUEUE_DEPTH = 2;

   // quotient bits of the band divider and its step counter
   localparam int QUO_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam int STEP_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;
   // offset into the window is below BAND_COUNT * max band size
   localparam int OFS_W  = $clog2(BAND_COUNT * 1023);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes
   localparam logic [2:0] REG_ZONE_MASK   = 3'd0;
   localparam logic [2:0] REG_VALID_CODE  = 3'd1;
   localparam logic [2:0] REG_LOW_BAR     = 3'd2;
   localparam logic [2:0] REG_BAND_SIZE   = 3'd3;
   localparam logic [2:0] REG_HIT_REQ     = 3'd4;

   // register reset values
   localparam logic [63:0] RST_ZONE_MASK  = 64'h6600;
   localparam logic [7:0]  RST_VALID_CODE = 8'd5;
   localparam logic [11:0] RST_LOW_BAR    = 12'd100;
   localparam logic [9:0]  RST_BAND_SIZE  = 10'd23;
   localparam logic [6:0]  RST_HIT_REQ    = 7'd1;

   typedef logic [MASK_BITS-1:0] mask_type;
   typedef logic [COUNT_W-1:0]   count_type;

   typedef struct packed {
      logic [63:0] zone_mask;
      logic [7:0]  valid_code;
      logic [11:0] low_bar;
      logic [9:0]  band_size;
      logic [6:0]  hit_req;
   } cfg_type;

   // one classified reading handed from front to back
   typedef struct packed {
      logic             hit;
      logic [OFS_W-1:0] offset;
      logic             end_sensor;
      logic             end_frame;
   } entry_type;

endpackage
`default_nettype wire

FILE: rtl/core/tzbo_front.sv
// Front end: accept readings, qualify them and compute the window offset.
`default_nettype none
module tzbo_front (
   input  wire logic              push,
   output logic                   full,
   input  wire logic [5:0]        req_zone_index,
   input  wire logic [2:0]        req_targets_detected,
   input  wire logic [7:0]        req_target_status,
   input  wire logic signed [15:0] req_distance_mm,
   input  wire logic              req_last_of_sensor,
   input  wire logic              req_last_of_frame,
   input  wire tzbo_pkg::cfg_type cfg,
   input  wire logic              q_full,
   output logic                   q_push,
   output tzbo_pkg::entry_type    q_entry
);
   import tzbo_pkg::*;

   logic        zone_on;
   logic [15:0] dist_u;
   logic [15:0] diff;
   logic [15:0] limit;
   logic        in_window;
   logic        hit;

   assign full = q_full;

   always_comb begin
      zone_on   = (7'(req_zone_index) < 7'(ZONE_COUNT)) && cfg.zone_mask[req_zone_index];
      dist_u    = req_distance_mm;
      diff      = dist_u - {4'd0, cfg.low_bar};
      limit     = 16'(BAND_COUNT) * {6'd0, cfg.band_size};
      // a zero band size leaves an empty window
      in_window = !dist_u[15] && (dist_u >= {4'd0, cfg.low_bar}) && (diff < limit);
      hit       = zone_on && (req_targets_detected != 3'd0) &&
                  (req_target_status == cfg.valid_code) && in_window;
   end

   always_comb begin
      q_entry.hit        = hit;
      q_entry.offset     = diff[OFS_W-1:0];
      q_entry.end_sensor = req_last_of_sensor | req_last_of_frame;
      q_entry.end_frame  = req_last_of_frame;
      // drop readings that neither hit nor close a sensor
      q_push = push && !q_full && (hit || req_last_of_sensor || req_last_of_frame);
   end

endmodule
`default_nettype wire

FILE: rtl/core/tzbo_queue.sv
// Short queue of classified readings between front and back.
`default_nettype none
module tzbo_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_push,
   input  wire tzbo_pkg::entry_type q_entry,
   output logic                     q_full,
   input  wire logic                q_pop,
   output logic                     q_empty,
   output tzbo_pkg::entry_type      q_head
);
   import tzbo_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = slot_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_entry;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/tzbo_back.sv
// Back end: band divider, hit counters, sensor fold and frame result register.
`default_nettype none
module tzbo_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tzbo_pkg::cfg_type   cfg,
   input  wire logic                q_empty,
   input  wire tzbo_pkg::entry_type q_head,
   output logic                     q_pop,
   output logic                     empty,
   input  wire logic                pop,
   output logic [5:0]               rsp_blocked_bands
);
   import tzbo_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_FOLD  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [OFS_W-1:0]  rem_ff, rem_in;
   logic [OFS_W-1:0]  div_ff, div_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              end_sensor_ff, end_sensor_in;
   logic              end_frame_ff, end_frame_in;
   count_type         cnt_ff [BAND_COUNT];
   count_type         cnt_in [BAND_COUNT];
   mask_type          frame_ff, frame_in;
   logic              out_valid_ff, out_valid_in;
   mask_type          out_bands_ff, out_bands_in;
   mask_type          fold_bits;
   logic              out_free;

   assign empty             = !out_valid_ff;
   assign rsp_blocked_bands = out_bands_ff;
   assign out_free          = !out_valid_ff || pop;

   always_comb begin
      fold_bits = '0;
      for (int j = 0; j < BAND_COUNT; j++) begin
         // bands past the mask width shift out
         if (cnt_ff[j] >= cfg.hit_req) begin
            fold_bits = fold_bits | (mask_type'(1) << j);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      end_sensor_in = end_sensor_ff;
      end_frame_in  = end_frame_ff;
      cnt_in        = cnt_ff;
      frame_in      = frame_ff;
      out_valid_in  = out_valid_ff && !pop;
      out_bands_in  = out_bands_ff;
      q_pop         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop         = 1'b1;
               rem_in        = q_head.offset;
               div_in        = OFS_W'({cfg.band_size, {(QUO_W - 1){1'b0}}});
               quo_in        = '0;
               step_in       = STEP_W'(QUO_W - 1);
               end_sensor_in = q_head.end_sensor;
               end_frame_in  = q_head.end_frame;
               if (q_head.hit) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_FOLD;
               end
            end
         end
         ST_DIV: begin
            // one restoring step: one quotient bit per cycle
            if (rem_ff >= div_ff) begin
               rem_in = rem_ff - div_ff;
               quo_in = (quo_ff << 1) | QUO_W'(1);
            end else begin
               quo_in = quo_ff << 1;
            end
            div_in  = div_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            for (int j = 0; j < BAND_COUNT; j++) begin
               if (quo_ff == QUO_W'(j) && cnt_ff[j] != COUNT_MAX) begin
                  cnt_in[j] = cnt_ff[j] + 1'b1;
               end
            end
            state_in = end_sensor_ff ? ST_FOLD : ST_IDLE;
         end
         ST_FOLD: begin
            // at a frame end, hold until the result register can take the frame mask
            if (!end_frame_ff || out_free) begin
               for (int j = 0; j < BAND_COUNT; j++) begin
                  cnt_in[j] = '0;
               end
               if (end_frame_ff) begin
                  out_valid_in = 1'b1;
                  out_bands_in = frame_ff | fold_bits;
                  frame_in     = '0;
               end else begin
                  frame_in = frame_ff | fold_bits;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < BAND_COUNT; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      end_sensor_ff <= end_sensor_in;
      end_frame_ff  <= end_frame_in;
      out_bands_ff  <= out_bands_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/tof_zone_band_occupancy.sv
// Top level of the zone band occupancy block: register file and front/queue/back.
`default_nettype none
// Counts qualified zone readings of a multizone distance sensor into distance
// bands and reports, once per frame, which bands some sensor saw often enough.
// A reading is a hit when its zone is enabled in zone_mask, it has at least one
// target, its status equals valid_status_code and its distance falls in
// [low_bar_mm, low_bar_mm + 6 * band_size_mm). The front end qualifies each
// reading in the transfer cycle and drops readings that neither hit nor close a
// sensor; the rest go into a two-entry queue. The back end takes one entry at a
// time: it takes the entry from the queue, then a hit passes through a
// shift-subtract divider that finds the band and then bumps that band's
// saturating counter, and a reading that closes a sensor then also folds the
// counters into the frame mask and clears them. A dropped reading never
// reaches the back end. At the end of a frame the mask goes to a one-deep
// result register, and the back end stalls there only while a previous mask
// has not been popped. Registers sit at byte addresses 8*i (64-bit data):
// 0 zone_mask, 1 status code, 2 low bar, 3 band size, 4 hit requirement.
// Write them only while idle.
module tof_zone_band_occupancy (
   input  wire logic               clock,
   input  wire logic               reset,
   // reading channel
   input  wire logic               push,
   output logic                    full,
   input  wire logic [5:0]         req_zone_index,
   input  wire logic [2:0]         req_targets_detected,
   input  wire logic [7:0]         req_target_status,
   input  wire logic signed [15:0] req_distance_mm,
   input  wire logic               req_last_of_sensor,
   input  wire logic               req_last_of_frame,
   // result channel
   output logic                    empty,
   input  wire logic               pop,
   output logic [5:0]              rsp_blocked_bands,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [5:0]         paddr,
   input  wire logic [63:0]        pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);
   import tzbo_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       reg_write;
   logic       q_push, q_full, q_pop, q_empty;
   entry_type  q_entry, q_head;

   // register file
   assign pready    = 1'b1;
   assign reg_index = paddr[5:3];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (reg_write) begin
         unique case (reg_index)
            REG_ZONE_MASK:  cfg_in.zone_mask  = pwdata;
            REG_VALID_CODE: cfg_in.valid_code = pwdata[7:0];
            REG_LOW_BAR:    cfg_in.low_bar    = pwdata[11:0];
            REG_BAND_SIZE:  cfg_in.band_size  = pwdata[9:0];
            REG_HIT_REQ:    cfg_in.hit_req    = pwdata[6:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ZONE_MASK:  prdata = cfg_ff.zone_mask;
         REG_VALID_CODE: prdata = {56'd0, cfg_ff.valid_code};
         REG_LOW_BAR:    prdata = {52'd0, cfg_ff.low_bar};
         REG_BAND_SIZE:  prdata = {54'd0, cfg_ff.band_size};
         REG_HIT_REQ:    prdata = {57'd0, cfg_ff.hit_req};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zone_mask  <= RST_ZONE_MASK;
         cfg_ff.valid_code <= RST_VALID_CODE;
         cfg_ff.low_bar    <= RST_LOW_BAR;
         cfg_ff.band_size  <= RST_BAND_SIZE;
         cfg_ff.hit_req    <= RST_HIT_REQ;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // qualify readings and compute the window offset
   tzbo_front u_front (
      .push                 (push),
      .full                 (full),
      .req_zone_index       (req_zone_index),
      .req_targets_detected (req_targets_detected),
      .req_target_status    (req_target_status),
      .req_distance_mm      (req_distance_mm),
      .req_last_of_sensor   (req_last_of_sensor),
      .req_last_of_frame    (req_last_of_frame),
      .cfg                  (cfg_ff),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_entry              (q_entry)
   );

   // decouple the front from the iterative back end
   tzbo_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // divide into a band, count, fold and emit
   tzbo_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_blocked_bands (rsp_blocked_bands)
   );

endmodule
`default_nettype wire
